// ----- rtl/elsq_pkg.sv -----
// Package for the expiry-sorted lot queue.
// Holds item types, opcode and status codes, and the controller/datapath interface.
// No dependencies.
package elsq_pkg;

  localparam int unsigned DefLotDepth = 16;

  localparam int unsigned KeyW    = 24;
  localparam int unsigned QtyW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LotsW   = 5;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_WITHDRAW = 1'b1;

  localparam logic [StatusW-1:0] ST_DONE    = 2'd0;
  localparam logic [StatusW-1:0] ST_DROPPED = 2'd1;
  localparam logic [StatusW-1:0] ST_SHORT   = 2'd2;

  typedef struct packed {
    logic            opcode;
    logic [KeyW-1:0] date_key;
    logic [QtyW-1:0] quantity;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [QtyW-1:0]    removed_units;
    logic [LotsW-1:0]   lots_in_use;
    logic [KeyW-1:0]    oldest_date;
    logic [QtyW-1:0]    oldest_units;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
  } dp_stat_t;

endpackage

// ----- rtl/elsq_datapath.sv -----
// Datapath of the expiry-sorted lot queue: sorted cell chain, withdraw
// remainder, and the output payload register. Depends on elsq_pkg.
module elsq_datapath #(
  parameter int unsigned LOT_DEPTH = elsq_pkg::DefLotDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  elsq_pkg::dp_cmd_t   cmd_i,
  output elsq_pkg::dp_stat_t  stat_o,
  input  elsq_pkg::in_item_t  in_data_i,
  output elsq_pkg::out_item_t out_data_o
);

  localparam int unsigned CW   = $clog2(LOT_DEPTH + 1);
  localparam int unsigned KW   = elsq_pkg::KeyW;
  localparam int unsigned QW   = elsq_pkg::QtyW;

  logic [KW-1:0] date_q [LOT_DEPTH];
  logic [KW-1:0] date_d [LOT_DEPTH];
  logic [QW-1:0] units_q [LOT_DEPTH];
  logic [QW-1:0] units_d [LOT_DEPTH];
  logic [CW-1:0] count_q, count_d;

  logic          op_q, op_d;
  logic [KW-1:0] key_q, key_d;
  logic [QW-1:0] qty_q, qty_d;
  logic [QW-1:0] rem_q, rem_d;
  logic          dropped_q, dropped_d;

  elsq_pkg::out_item_t out_q, out_d;

  logic [LOT_DEPTH-1:0] used, lt, eq;
  logic                 any_eq, full, ge;
  logic [QW:0]          diff;
  logic [QW:0]          sum [LOT_DEPTH];

  always_comb begin
    for (int i = 0; i < LOT_DEPTH; i++) begin
      used[i] = CW'(i) < count_q;
      lt[i]   = used[i] && (date_q[i] < key_q);
      eq[i]   = used[i] && (date_q[i] == key_q);
      sum[i]  = {1'b0, units_q[i]} + {1'b0, qty_q};
    end
    any_eq = |eq;
    full   = count_q == CW'(LOT_DEPTH);
    diff   = {1'b0, rem_q} - {1'b0, units_q[0]};
    ge     = !diff[QW];
  end

  assign stat_o.more = (rem_q != '0) && (count_q != '0);

  always_comb begin
    date_d    = date_q;
    units_d   = units_q;
    count_d   = count_q;
    op_d      = op_q;
    key_d     = key_q;
    qty_d     = qty_q;
    rem_d     = rem_q;
    dropped_d = dropped_q;

    if (cmd_i.load) begin
      op_d  = in_data_i.opcode;
      key_d = in_data_i.date_key;
      qty_d = in_data_i.quantity;
      rem_d = in_data_i.quantity;
    end

    if (cmd_i.insert) begin
      dropped_d = !any_eq && full;
      if (any_eq) begin
        for (int i = 0; i < LOT_DEPTH; i++) begin
          if (eq[i]) begin
            units_d[i] = sum[i][QW] ? '1 : sum[i][QW-1:0];
          end
        end
      end else if (!full) begin
        if (!lt[0]) begin
          date_d[0]  = key_q;
          units_d[0] = qty_q;
        end
        for (int i = 1; i < LOT_DEPTH; i++) begin
          if (!lt[i] && lt[i-1]) begin
            date_d[i]  = key_q;
            units_d[i] = qty_q;
          end else if (!lt[i-1]) begin
            date_d[i]  = date_q[i-1];
            units_d[i] = units_q[i-1];
          end
        end
        count_d = count_q + CW'(1);
      end
    end

    if (cmd_i.step) begin
      if (ge) begin
        for (int i = 0; i < LOT_DEPTH - 1; i++) begin
          date_d[i]  = date_q[i+1];
          units_d[i] = units_q[i+1];
        end
        count_d = count_q - CW'(1);
        rem_d   = diff[QW-1:0];
      end else begin
        units_d[0] = units_q[0] - rem_q;
        rem_d      = '0;
      end
    end
  end

  always_comb begin
    out_d.lots_in_use = elsq_pkg::LotsW'(count_q);
    if (count_q != '0) begin
      out_d.oldest_date  = date_q[0];
      out_d.oldest_units = units_q[0];
    end else begin
      out_d.oldest_date  = '0;
      out_d.oldest_units = '0;
    end
    if (op_q == elsq_pkg::OP_WITHDRAW) begin
      out_d.removed_units = qty_q - rem_q;
      out_d.status        = (rem_q != '0) ? elsq_pkg::ST_SHORT : elsq_pkg::ST_DONE;
    end else begin
      out_d.removed_units = '0;
      out_d.status        = dropped_q ? elsq_pkg::ST_DROPPED : elsq_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    date_q    <= date_d;
    units_q   <= units_d;
    op_q      <= op_d;
    key_q     <= key_d;
    qty_q     <= qty_d;
    rem_q     <= rem_d;
    dropped_q <= dropped_d;
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LOT_DEPTH))
    else $error("lot count exceeds depth");

  a_step_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> stat_o.more)
    else $error("withdraw step with nothing owed or no lots");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(2)) |-> (date_q[0] < date_q[1]))
    else $error("head lots out of order");

endmodule

// ----- rtl/elsq_ctrl.sv -----
// Controller of the expiry-sorted lot queue: sequences load, insert,
// withdraw steps and result hand-off. Depends on elsq_pkg.
module elsq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_opcode_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output elsq_pkg::dp_cmd_t  cmd_o,
  input  elsq_pkg::dp_stat_t stat_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_WITHDRAW,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_opcode_i == elsq_pkg::OP_INSERT) ? S_INSERT : S_WITHDRAW;
        end
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = S_FINISH;
      end
      S_WITHDRAW: begin
        if (stat_i.more) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free)
    else $error("result register overwritten while stalled");

  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> out_valid_q)
    else $error("finished item produced no result");

  a_insert_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT) |=> (state_q == S_FINISH))
    else $error("insert did not complete in one cycle");

endmodule

// ----- rtl/expiry_sorted_lot_queue.sv -----
// Top level of the expiry-sorted lot queue.
// Instantiates elsq_ctrl and elsq_datapath; depends on elsq_pkg.
//
// Usage:
//   Input channel in_valid_i/in_stall_o/in_data_i carries one item: insert
//   (add units under a date key) or withdraw (remove units oldest first).
//   Output channel out_valid_o/out_stall_i/out_data_o carries one result per
//   item with status, removed units, lot count and the oldest lot.
//   A transfer happens on a rising edge with valid high and stall low.
// Insert and withdraw:
//   Insert: after the input transfer, compare and shift in the cell chain
//   happen in S_INSERT; the result is then handed off from S_FINISH.
//   Withdraw: in S_WITHDRAW, 0..LOT_DEPTH lots are drained or trimmed; the
//   head of the cell chain is retired one lot per cycle.
//   A new item is taken only in S_IDLE; in_stall_o is high while one is in work.
// Reset:
//   Asynchronous, active low; the table comes up empty, no result pending.
// Receiver stall:
//   A finished result holds in the output register. The next item is still
//   accepted and worked on; it waits to hand off until that result is taken.
module expiry_sorted_lot_queue #(
  parameter int unsigned LOT_DEPTH = elsq_pkg::DefLotDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  elsq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output elsq_pkg::out_item_t out_data_o
);

  elsq_pkg::dp_cmd_t  cmd;
  elsq_pkg::dp_stat_t stat;

  elsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  elsq_datapath #(
    .LOT_DEPTH (LOT_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
